FILE: src/sfla_pkg.sv
// package for the sorted free list allocator
// table geometry, status codes and controller states; no dependencies
package sfla_pkg;
	localparam int unsigned TableEntries = 1024;
	localparam int unsigned IdxW = $clog2(TableEntries);
	localparam int unsigned CountW = 11;

	localparam logic [31:0] PageAdd = 32'h0000_0fff;
	localparam logic [31:0] PageMask = 32'hffff_f000;

	typedef logic [1:0] status_t;
	localparam status_t StatusOk = 2'd0;
	localparam status_t StatusNoSpace = 2'd1;
	localparam status_t StatusLost = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CK,
		ST_FREE_DEC,
		ST_SHD_RD,
		ST_SHD_WR,
		ST_SHU_RD,
		ST_SHU_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
	} entry_t;
endpackage

FILE: src/sorted_free_list_allocator_unit.sv
// first-fit allocator over an address-ordered free table held in one ram
// depends on sfla_pkg
// each item scans table entries in order, then moves entries one place up or
// down where one is inserted or removed, all through the single ram read port;
// one item at a time: a new item is taken only once the result strobe has shown.
// busy is high until the result strobe (done) has shown.
// reset empties the table and clears all counters; no clearing pass needed.
// the receiver cannot stall: each result is shown for exactly one cycle.
module sorted_free_list_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [31:0]                 block_address,
	input  logic [31:0]                 block_size,
	input  logic                        page_round,
	output logic                        done,
	output logic [31:0]                 granted_address,
	output sfla_pkg::status_t           status,
	output logic [31:0]                 total_free,
	output logic [sfla_pkg::CountW-1:0] region_count,
	output logic [sfla_pkg::CountW-1:0] peak_region_count,
	output logic [31:0]                 lost_frees,
	output logic [31:0]                 lost_bytes
);
	import sfla_pkg::*;

	state_t state_q, state_d;

	// item and working registers
	logic               op_q;
	logic [31:0]        addr_q, size_q;
	logic [CountW-1:0]  idx_q, k_q;
	entry_t             prev_q, cur_q;
	logic [31:0]        granted_q;
	status_t            status_q;
	logic [CountW-1:0]  used_q, peak_q;
	logic [31:0]        sum_q, lost_cnt_q, lost_bytes_q;

	// ram ports
	entry_t             mem [TableEntries];
	entry_t             rdata_q;
	logic               re, we;
	logic [IdxW-1:0]    raddr, waddr;
	entry_t             wdata;

	logic [31:0]        size_in;
	logic [CountW-1:0]  k_inc, k_dec;
	logic               fit, has_prev, has_next, merge_prev, merge_next;
	logic [31:0]        alloc_len;

	// table storage, registered read data
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign size_in = page_round ? ((block_size + PageAdd) & PageMask) : block_size;
	assign k_inc = k_q + 1'b1;
	assign k_dec = k_q - 1'b1;
	assign fit = rdata_q.length >= size_q;
	assign alloc_len = rdata_q.length - size_q;
	assign has_prev = idx_q != '0;
	assign has_next = idx_q < used_q;
	assign merge_prev = has_prev && ((prev_q.start + prev_q.length) == addr_q);
	assign merge_next = has_next && ((addr_q + size_q) == cur_q.start);

	// next state and ram control
	always_comb begin
		state_d = state_q;
		re = 1'b0;
		we = 1'b0;
		raddr = idx_q[IdxW-1:0];
		waddr = idx_q[IdxW-1:0];
		wdata = rdata_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN_RD;
			ST_SCAN_RD: begin
				if (idx_q == used_q) begin
					state_d = op_q ? ST_FREE_DEC : ST_DONE;
				end else begin
					re = 1'b1;
					state_d = ST_SCAN_CK;
				end
			end
			ST_SCAN_CK: begin
				if (!op_q) begin
					if (fit) begin
						if (alloc_len == '0) begin
							state_d = ST_SHD_RD;
						end else begin
							we = 1'b1;
							wdata.start = rdata_q.start + size_q;
							wdata.length = alloc_len;
							state_d = ST_DONE;
						end
					end else begin
						state_d = ST_SCAN_RD;
					end
				end else if (rdata_q.start > addr_q) begin
					state_d = ST_FREE_DEC;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_FREE_DEC: begin
				if (merge_prev) begin
					we = 1'b1;
					waddr = idx_q[IdxW-1:0] - 1'b1;
					wdata.start = prev_q.start;
					wdata.length = merge_next ? (prev_q.length + size_q + cur_q.length)
						: (prev_q.length + size_q);
					state_d = merge_next ? ST_SHD_RD : ST_DONE;
				end else if (merge_next) begin
					we = 1'b1;
					wdata.start = addr_q;
					wdata.length = cur_q.length + size_q;
					state_d = ST_DONE;
				end else if (used_q < CountW'(TableEntries)) begin
					state_d = ST_SHU_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			// move entries down one place over a removed entry
			ST_SHD_RD: begin
				raddr = k_inc[IdxW-1:0];
				if (k_q >= used_q) begin
					state_d = ST_DONE;
				end else begin
					re = 1'b1;
					state_d = ST_SHD_WR;
				end
			end
			ST_SHD_WR: begin
				we = 1'b1;
				waddr = k_q[IdxW-1:0];
				state_d = ST_SHD_RD;
			end
			// move entries up one place to open a gap, then write the new entry
			ST_SHU_RD: begin
				raddr = k_dec[IdxW-1:0];
				if (k_q == idx_q) begin
					we = 1'b1;
					wdata.start = addr_q;
					wdata.length = size_q;
					state_d = ST_DONE;
				end else begin
					re = 1'b1;
					state_d = ST_SHU_WR;
				end
			end
			ST_SHU_WR: begin
				we = 1'b1;
				waddr = k_q[IdxW-1:0];
				state_d = ST_SHU_RD;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// free byte, region, peak and lost counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			peak_q <= '0;
			sum_q <= '0;
			lost_cnt_q <= '0;
			lost_bytes_q <= '0;
		end else begin
			case (state_q)
				ST_SCAN_CK: begin
					if (!op_q && fit) begin
						sum_q <= sum_q - size_q;
						if (alloc_len == '0) used_q <= used_q - 1'b1;
					end
				end
				ST_FREE_DEC: begin
					if (merge_prev || merge_next) begin
						sum_q <= sum_q + size_q;
						if (merge_prev && merge_next) used_q <= used_q - 1'b1;
					end else if (used_q >= CountW'(TableEntries)) begin
						lost_cnt_q <= lost_cnt_q + 1'b1;
						lost_bytes_q <= lost_bytes_q + size_q;
					end
				end
				ST_SHU_RD: begin
					if (k_q == idx_q) begin
						used_q <= used_q + 1'b1;
						sum_q <= sum_q + size_q;
						if (peak_q < used_q + 1'b1) peak_q <= used_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// item payload and scan registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= action;
				addr_q <= block_address;
				size_q <= size_in;
				idx_q <= '0;
				granted_q <= '0;
				status_q <= action ? StatusOk : StatusNoSpace;
			end
			ST_SCAN_CK: begin
				cur_q <= rdata_q;
				k_q <= idx_q;
				if (!op_q) begin
					if (fit) begin
						granted_q <= rdata_q.start;
						status_q <= StatusOk;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end else if (!(rdata_q.start > addr_q)) begin
					prev_q <= rdata_q;
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_FREE_DEC: begin
				k_q <= merge_prev ? idx_q : used_q;
				if (!merge_prev && !merge_next && used_q >= CountW'(TableEntries))
					status_q <= StatusLost;
			end
			ST_SHD_WR: k_q <= k_inc;
			ST_SHU_WR: k_q <= k_dec;
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;
	assign granted_address = granted_q;
	assign status = status_q;
	assign total_free = sum_q;
	assign region_count = used_q;
	assign peak_region_count = peak_q;
	assign lost_frees = lost_cnt_q;
	assign lost_bytes = lost_bytes_q;
endmodule

FILE: tb/sv/sorted_free_list_allocator_unit_test.sv
// testbench for the sorted free list allocator: directed and random items
// checked against an in-bench first-fit free table model; depends on sfla_pkg
module sorted_free_list_allocator_unit_test;
	import sfla_pkg::*;

	typedef struct {
		logic [31:0]        granted;
		status_t            status;
		logic [31:0]        total;
		logic [CountW-1:0]  count;
		logic [CountW-1:0]  peak;
		logic [31:0]        lost_n;
		logic [31:0]        lost_b;
	} outcome_t;

	typedef struct {
		logic [31:0] addr;
		logic [31:0] size;
	} block_t;

	localparam logic ActAlloc = 1'b0;
	localparam logic ActFree = 1'b1;
	localparam int StallLimit = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic [31:0] block_address;
	logic [31:0] block_size;
	logic page_round;
	logic done;
	logic [31:0] granted_address;
	status_t status;
	logic [31:0] total_free;
	logic [CountW-1:0] region_count;
	logic [CountW-1:0] peak_region_count;
	logic [31:0] lost_frees;
	logic [31:0] lost_bytes;

	sorted_free_list_allocator_unit dut (.*);

	// model of the free table
	logic [31:0] tbl_start [TableEntries];
	logic [31:0] tbl_len [TableEntries];
	int unsigned tbl_used;
	int unsigned tbl_peak;
	logic [31:0] lost_count;
	logic [31:0] lost_sum;
	logic [31:0] free_total;

	outcome_t pending_results[$];
	block_t held_blocks[$];
	int mismatches;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void drop_entry(int unsigned pos);
		tbl_used--;
		for (int unsigned k = pos; k < tbl_used; k++) begin
			tbl_start[k] = tbl_start[k + 1];
			tbl_len[k] = tbl_len[k + 1];
		end
	endfunction

	function automatic int unsigned order_pos(logic [31:0] addr);
		int unsigned pos;
		pos = 0;
		while (pos < tbl_used && tbl_start[pos] <= addr)
			pos++;
		return pos;
	endfunction

	// first-fit allocate or coalescing free, returns the expected result
	function automatic outcome_t predict_outcome(logic act, logic [31:0] addr,
			logic [31:0] size, logic rnd);
		outcome_t r;
		int unsigned pos;
		bit found;
		r.granted = '0;
		found = 0;
		if (rnd)
			size = (size + PageAdd) & PageMask;
		if (act == ActAlloc) begin
			for (int unsigned k = 0; k < tbl_used && !found; k++) begin
				if (tbl_len[k] >= size) begin
					found = 1;
					r.granted = tbl_start[k];
					tbl_start[k] += size;
					tbl_len[k] -= size;
					free_total -= size;
					if (tbl_len[k] == 0)
						drop_entry(k);
				end
			end
			r.status = found ? StatusOk : StatusNoSpace;
		end else begin
			pos = order_pos(addr);
			r.status = StatusOk;
			if (pos > 0 && tbl_start[pos - 1] + tbl_len[pos - 1] == addr) begin
				tbl_len[pos - 1] += size;
				if (pos < tbl_used && addr + size == tbl_start[pos]) begin
					tbl_len[pos - 1] += tbl_len[pos];
					drop_entry(pos);
				end
				free_total += size;
			end else if (pos < tbl_used && addr + size == tbl_start[pos]) begin
				tbl_start[pos] = addr;
				tbl_len[pos] += size;
				free_total += size;
			end else if (tbl_used < TableEntries) begin
				for (int unsigned k = tbl_used; k > pos; k--) begin
					tbl_start[k] = tbl_start[k - 1];
					tbl_len[k] = tbl_len[k - 1];
				end
				tbl_used++;
				if (tbl_peak < tbl_used)
					tbl_peak = tbl_used;
				tbl_start[pos] = addr;
				tbl_len[pos] = size;
				free_total += size;
			end else begin
				lost_count++;
				lost_sum += size;
				r.status = StatusLost;
			end
		end
		if (act == ActAlloc && found && size != 0) begin
			held_blocks.push_back('{addr: r.granted, size: size});
		end
		r.total = free_total;
		r.count = tbl_used[CountW-1:0];
		r.peak = tbl_peak[CountW-1:0];
		r.lost_n = lost_count;
		r.lost_b = lost_sum;
		return r;
	endfunction

	// send one item after a random gap; start stays high across back-to-back items
	task automatic send_item(logic act, logic [31:0] addr, logic [31:0] size, logic rnd);
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		block_address <= addr;
		block_size <= size;
		page_round <= rnd;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_outcome(act, addr, size, rnd));
	endtask

	// compare each result strobe with the oldest expectation
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no item outstanding: addr %h status %0d",
						granted_address, status);
			end else begin
				e = pending_results.pop_front();
				if (granted_address !== e.granted || status !== e.status ||
						total_free !== e.total || region_count !== e.count ||
						peak_region_count !== e.peak || lost_frees !== e.lost_n ||
						lost_bytes !== e.lost_b) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: addr %h st %0d total %h cnt %0d peak %0d lost %0d/%h",
							e.granted, e.status, e.total, e.count, e.peak, e.lost_n, e.lost_b);
						$display("         got: addr %h st %0d total %h cnt %0d peak %0d lost %0d/%h",
							granted_address, status, total_free, region_count,
							peak_region_count, lost_frees, lost_bytes);
					end
				end
			end
		end
	end

	// watchdog on cycles with no item accepted and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// extremes, merges, wrap and zero sizes with only a few table entries in use
	task automatic test_directed;
		send_item(ActAlloc, 32'h0, 32'h10, 1'b0);
		send_item(ActAlloc, 32'hffff_ffff, 32'h0, 1'b0);
		send_item(ActFree, 32'h0, 32'h1000, 1'b0);
		send_item(ActAlloc, 32'h1234_5678, 32'h1, 1'b1);
		send_item(ActFree, 32'h0, 32'h1000, 1'b0);
		send_item(ActFree, 32'h3000, 32'h1000, 1'b0);
		send_item(ActFree, 32'h2000, 32'h1000, 1'b0);
		send_item(ActFree, 32'h1000, 32'h1000, 1'b0);
		send_item(ActFree, 32'h8000, 32'h0, 1'b0);
		send_item(ActAlloc, 32'h0, 32'h0, 1'b0);
		send_item(ActFree, 32'h9000, 32'h0, 1'b0);
		send_item(ActAlloc, 32'h0, 32'h4000, 1'b0);
		send_item(ActAlloc, 32'h0, 32'h0, 1'b0);
		send_item(ActAlloc, 32'h0, 32'h0, 1'b0);
		send_item(ActFree, 32'hffff_f000, 32'hffff_ffff, 1'b1);
		send_item(ActFree, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		send_item(ActFree, 32'h7fff_0000, 32'h8000_1000, 1'b0);
		send_item(ActAlloc, 32'h0, 32'hffff_ffff, 1'b0);
		send_item(ActAlloc, 32'h0, 32'hffff_ffff, 1'b1);
		send_item(ActAlloc, 32'h0, 32'h0000_1001, 1'b1);
		send_item(ActFree, 32'h5555_5555, 32'haaaa_aaaa, 1'b1);
		send_item(ActAlloc, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
	endtask

	// mostly frees of granted blocks and fitting allocations, some noise
	task automatic test_random(int n);
		block_t b;
		int idx;
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3)
				send_item(ActAlloc, $urandom, $urandom_range(1, 'h3000),
					1'($urandom_range(0, 1)));
			else if (kind <= 7 && held_blocks.size() > 0) begin
				idx = $urandom_range(0, held_blocks.size() - 1);
				b = held_blocks[idx];
				held_blocks.delete(idx);
				send_item(ActFree, b.addr, b.size, 1'b0);
			end else if (kind <= 8)
				send_item(ActFree, $urandom, $urandom >> $urandom_range(0, 20),
					1'($urandom_range(0, 1)));
			else
				send_item(ActAlloc, $urandom, $urandom, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		block_address = '0;
		block_size = '0;
		page_round = 1'b0;
		tbl_used = 0;
		tbl_peak = 0;
		lost_count = '0;
		lost_sum = '0;
		free_total = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(268);

		start <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
